// ----- src/tclp_pkg.sv -----
// Shared types, constants and lookup functions for the command line parser.
package tclp_pkg;

    localparam int LINE_CHARS = 64;
    localparam int WORD_COUNT = 8;
    localparam int TABLE_MAX  = 8;
    localparam int BOOT_MIN_CHARS = 9;
    localparam int OUT_PAD_W  = 7;

    typedef logic [3:0] cmd_t;
    localparam cmd_t CMD_EMPTY   = 4'd0;
    localparam cmd_t CMD_BOOT    = 4'd1;
    localparam cmd_t CMD_HELP    = 4'd2;
    localparam cmd_t CMD_CLEAR   = 4'd3;
    localparam cmd_t CMD_MD      = 4'd4;
    localparam cmd_t CMD_MW      = 4'd5;
    localparam cmd_t CMD_MTEST   = 4'd6;
    localparam cmd_t CMD_CACHE_CTL = 4'd7;
    localparam cmd_t CMD_VERSION = 4'd8;
    localparam cmd_t CMD_UNKNOWN = 4'd9;

    localparam logic [1:0] TGT_NONE  = 2'd0;
    localparam logic [1:0] TGT_ICACHE = 2'd1;
    localparam logic [1:0] TGT_DCACHE = 2'd2;

    localparam logic [1:0] ACT_INVALIDATE = 2'd0;
    localparam logic [1:0] ACT_DISABLE    = 2'd1;
    localparam logic [1:0] ACT_ENABLE     = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_D     = 8'h64;

    typedef enum logic [5:0] {
        PH_NAME   = 6'b000001,
        PH_SKIP   = 6'b000010,
        PH_DASHED = 6'b000100,
        PH_LEAD0  = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [1:0]  tgt;
        logic [31:0] v2;
        logic [31:0] v1;
        logic        err;
        cmd_t        code;
    } result_t;

    // Command word text, first character in the top byte.
    function automatic logic [63:0] word_text(input logic [2:0] w);
        logic [63:0] t;
        case (w)
            3'd0:    t = {"boot", 32'd0};
            3'd1:    t = {"help", 32'd0};
            3'd2:    t = {"clear", 24'd0};
            3'd3:    t = {"md", 48'd0};
            3'd4:    t = {"mw", 48'd0};
            3'd5:    t = {"mtest", 24'd0};
            3'd6:    t = {"cache", 24'd0};
            3'd7:    t = {"version", 8'd0};
            default: t = 64'd0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] p);
        logic [63:0] t;
        t = word_text(w);
        return t[8 * (7 - int'(p)) +: 8];
    endfunction

    function automatic logic [3:0] word_len(input logic [2:0] w);
        logic [3:0] n;
        case (w)
            3'd0:    n = 4'd4;
            3'd1:    n = 4'd4;
            3'd2:    n = 4'd5;
            3'd3:    n = 4'd2;
            3'd4:    n = 4'd2;
            3'd5:    n = 4'd5;
            3'd6:    n = 4'd5;
            3'd7:    n = 4'd7;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // {valid, digit}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
            r = {1'b1, 4'(c - "0")};
        else if (c >= "a" && c <= "f")
            r = {1'b1, 4'(c - "a" + 8'd10)};
        else if (c >= "A" && c <= "F")
            r = {1'b1, 4'(c - "A" + 8'd10)};
        return r;
    endfunction

endpackage

// ----- src/text_command_line_parser.sv -----
// Console command line parser: one character per transaction, one result per line.
//
//  channel | dir | tdata fields (low bit up)                                   | tlast
//  s_*     | in  | [7:0] char_code                                             | end_of_line
//  m_*     | out | [3:0] command_code, [4] parse_error, [36:5] first_value,     | -
//          |     | [68:37] second_value, [70:69] cache_target, [72:71] action   |
//
// One transaction per cycle sustained; a character is registered, then folded
// into the parse state the next cycle; an end-of-line goes through the input
// register and then the result register before m_tvalid rises. The input and
// result registers decouple the sides; only an end-of-line waiting on a full
// result register stalls the input. Reset returns to the start-of-line state.
module text_command_line_parser #(
    parameter int LINE_CHARS = tclp_pkg::LINE_CHARS,
    parameter int WORD_COUNT = tclp_pkg::WORD_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // code, error, first, second, target, action, pad
);
    import tclp_pkg::*;

    localparam int CountW     = $clog2(LINE_CHARS + 1);
    localparam int TableWords = (WORD_COUNT < TABLE_MAX) ? WORD_COUNT : TABLE_MAX;

    // input register
    logic       in_v_reg;
    logic [7:0] ch_reg;
    logic       eol_reg;

    // parse state
    logic [CountW-1:0]     line_count_reg, line_count_next;
    phase_t                phase_reg, phase_next;
    logic [TableWords-1:0] mask_reg, mask_next;
    logic [1:0]            field_reg, field_next;
    logic [31:0]           op_reg [3];
    logic [31:0]           op_next [3];
    logic [7:0]            cache_chr_reg [2];
    logic [7:0]            cache_chr_next [2];
    logic [1:0]            cache_cnt_reg, cache_cnt_next;
    logic                  ended_reg, ended_next;

    // result register
    logic    out_v_reg;
    result_t out_reg, res;

    logic        out_free, proc_fire, take_char;
    logic        sp, is_dash, is_zero, is_x, is_hex;
    logic [3:0]  dig;
    logic [4:0]  hx;
    logic [31:0] op_cur;
    logic        op_we;
    logic        fail;

    assign out_free  = !out_v_reg || m_tready;
    assign proc_fire = in_v_reg && (!eol_reg || out_free);
    assign s_tready  = !in_v_reg || proc_fire;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = {{OUT_PAD_W{1'b0}}, out_reg};

    assign take_char = proc_fire && !eol_reg && !ended_reg
                       && (line_count_reg < CountW'(LINE_CHARS));

    assign hx      = hex_val(ch_reg);
    assign is_hex  = hx[4];
    assign dig     = hx[3:0];
    assign sp      = (ch_reg == CH_SPACE);
    assign is_dash = (ch_reg == CH_DASH);
    assign is_zero = (ch_reg == CH_ZERO);
    assign is_x    = (ch_reg == CH_X);

    always_comb
    begin
        op_cur = 32'd0;
        for (int k = 0; k < 3; k++)
        begin
            if (field_reg == 2'(k))
                op_cur = op_reg[k];
        end
    end

    // character path
    always_comb
    begin
        line_count_next = line_count_reg;
        phase_next      = phase_reg;
        mask_next       = mask_reg;
        field_next      = field_reg;
        cache_cnt_next  = cache_cnt_reg;
        ended_next      = ended_reg;
        op_we           = 1'b0;
        fail            = 1'b0;
        for (int k = 0; k < 3; k++)
            op_next[k] = op_reg[k];
        for (int k = 0; k < 2; k++)
            cache_chr_next[k] = cache_chr_reg[k];

        if (take_char)
        begin
            if (ch_reg == CH_NUL)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                for (int i = 0; i < TableWords; i++)
                begin
                    if (line_count_reg < CountW'(word_len(3'(i)))
                        && word_char(3'(i), line_count_reg[2:0]) != ch_reg)
                        mask_next[i] = 1'b0;
                end

                case (phase_reg)
                    PH_NAME:
                    begin
                        if (sp)
                            phase_next = PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        // operand start: optional dash, optional 0x, digits
                        if (!sp)
                        begin
                            if (is_dash)
                                phase_next = PH_DASHED;
                            else if (is_zero)
                                phase_next = PH_LEAD0;
                            else if (is_hex)
                            begin
                                phase_next = PH_DIGITS;
                                op_we      = 1'b1;
                            end
                            else
                                phase_next = PH_DONE;
                        end
                    end
                    PH_DASHED:
                    begin
                        if (is_zero)
                            phase_next = PH_LEAD0;
                        else if (is_hex)
                        begin
                            phase_next = PH_DIGITS;
                            op_we      = 1'b1;
                        end
                        else
                            fail = 1'b1;
                    end
                    PH_LEAD0:
                    begin
                        if (is_x)
                            phase_next = PH_DIGITS;
                        else if (is_hex)
                        begin
                            phase_next = PH_DIGITS;
                            op_we      = 1'b1;
                        end
                        else
                            fail = 1'b1;
                    end
                    PH_DIGITS:
                    begin
                        if (is_hex)
                            op_we = 1'b1;
                        else
                            fail = 1'b1;
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase

                // non-hex ends the operand; the same char may open the next one
                if (fail)
                begin
                    if (field_reg == 2'd2)
                        phase_next = PH_DONE;
                    else if (sp)
                    begin
                        phase_next = PH_SKIP;
                        field_next = field_reg + 2'd1;
                    end
                    else if (is_dash)
                    begin
                        phase_next = PH_DASHED;
                        field_next = field_reg + 2'd1;
                    end
                    else
                        phase_next = PH_DONE;
                end

                if (op_we)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (field_reg == 2'(k))
                            op_next[k] = {op_cur[27:0], dig};
                    end
                end

                if (phase_reg != PH_NAME && cache_cnt_reg < 2'd2 && !sp)
                begin
                    cache_chr_next[cache_cnt_reg[0]] = ch_reg;
                    cache_cnt_next = cache_cnt_reg + 2'd1;
                end

                line_count_next = line_count_reg + CountW'(1);
            end
        end

        // end of line: back to the start-of-line state
        if (proc_fire && eol_reg)
        begin
            line_count_next = '0;
            phase_next      = PH_NAME;
            mask_next       = '1;
            field_next      = 2'd0;
            cache_cnt_next  = 2'd0;
            ended_next      = 1'b0;
            for (int k = 0; k < 3; k++)
                op_next[k] = 32'd0;
            for (int k = 0; k < 2; k++)
                cache_chr_next[k] = 8'd0;
        end
    end

    // line result
    always_comb
    begin
        res = '0;
        if (line_count_reg == '0)
            res.code = CMD_EMPTY;
        else
        begin
            res.code = CMD_UNKNOWN;
            for (int i = TableWords - 1; i >= 0; i--)
            begin
                if (mask_reg[i] && line_count_reg >= CountW'(word_len(3'(i))))
                    res.code = 4'(i + 1);
            end
        end

        case (res.code)
            CMD_BOOT:
            begin
                if (line_count_reg >= CountW'(BOOT_MIN_CHARS))
                begin
                    res.v1  = op_reg[0];
                    res.v2  = op_reg[2];
                    res.err = (op_reg[0] == 32'd0) || (op_reg[2] == 32'd0);
                end
            end
            CMD_MD, CMD_MW:
            begin
                res.v1  = op_reg[0];
                res.v2  = op_reg[1];
                res.err = (op_reg[1] == 32'd0);
            end
            CMD_CACHE_CTL:
            begin
                if (cache_chr_reg[0] == CH_I)
                    res.tgt = TGT_ICACHE;
                else if (cache_chr_reg[0] == CH_D)
                    res.tgt = TGT_DCACHE;
                else
                    res.tgt = TGT_NONE;

                if (res.tgt == TGT_NONE)
                    res.err = 1'b1;
                else if (cache_chr_reg[1] == CH_I)
                    res.act = ACT_INVALIDATE;
                else if (cache_chr_reg[1] == CH_ZERO)
                    res.act = ACT_DISABLE;
                else
                    res.act = ACT_ENABLE;
            end
            default:
            begin
                res.err = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
            line_count_reg <= '0;
            phase_reg      <= PH_NAME;
            mask_reg       <= '1;
            field_reg      <= 2'd0;
            cache_cnt_reg  <= 2'd0;
            ended_reg      <= 1'b0;
            for (int k = 0; k < 3; k++)
                op_reg[k] <= 32'd0;
            for (int k = 0; k < 2; k++)
                cache_chr_reg[k] <= 8'd0;
        end
        else
        begin
            if (s_tready)
                in_v_reg <= s_tvalid;
            if (proc_fire && eol_reg)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
            line_count_reg <= line_count_next;
            phase_reg      <= phase_next;
            mask_reg       <= mask_next;
            field_reg      <= field_next;
            cache_cnt_reg  <= cache_cnt_next;
            ended_reg      <= ended_next;
            for (int k = 0; k < 3; k++)
                op_reg[k] <= op_next[k];
            for (int k = 0; k < 2; k++)
                cache_chr_reg[k] <= cache_chr_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            ch_reg  <= s_tdata;
            eol_reg <= s_tlast;
        end
        if (proc_fire && eol_reg)
            out_reg <= res;
    end

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && eol_reg |=> line_count_reg == '0 && mask_reg == '1
                                 && phase_reg == PH_NAME)
        else $error("parse state not cleared after end of line");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(proc_fire && eol_reg))
        else $error("result raised without an end-of-line transaction");

    a_error_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_reg.err |-> out_reg.code == CMD_BOOT || out_reg.code == CMD_MD
                                     || out_reg.code == CMD_MW
                                     || out_reg.code == CMD_CACHE_CTL)
        else $error("parse error flagged for a command without operands");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg <= CountW'(LINE_CHARS))
        else $error("line count beyond line length");

endmodule
